### src/trs_hierarchy_compose_defines.svh
// Assertion macros for the RTL files (included by the controller)
`ifndef TRS_HIERARCHY_COMPOSE_DEFINES_SVH
`define TRS_HIERARCHY_COMPOSE_DEFINES_SVH
// a implies b in the next cycle
`define TRS_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
// a implies b in the same cycle
`define TRS_ASSERT_NOW(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
`endif

### src/trs_pkg.sv
// Package: types and constants of the transform composer
package trs_pkg;
   localparam int COORD_WIDTH_DEF = 32;
   localparam int MUL_W = 33;
   localparam int ACC_W = 72;

   typedef enum logic [2:0] {
      ST_IDLE, ST_ROT, ST_TRANS, ST_LIN, ST_SCALE, ST_OUT
   } trs_state_type;

   // operand select codes for the shared multiplier
   typedef enum logic [1:0] {
      OP_ROT, OP_TRANS, OP_LIN, OP_SCALE
   } trs_op_type;

   typedef struct packed {
      logic       load;
      trs_op_type op;
      logic [1:0] i;
      logic [1:0] j;
      logic [1:0] k;
      logic       acc_clr;
      logic       acc_en;
      logic       store;
      logic       commit;
   } trs_cmd_type;
endpackage

### src/trs_if.sv
// Valid/ready channel interface
interface trs_if #(parameter int W = 8);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### src/trs_ctrl.sv
// Controller: sequences the multiply-accumulate steps of one level
module trs_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic               in_last,
   output logic               in_ready,
   output logic               out_valid,
   input  logic               out_ready,
   output trs_pkg::trs_cmd_type cmd
);
   import trs_pkg::*;
   `include "trs_hierarchy_compose_defines.svh"

   trs_state_type state_ff, state_in;
   logic [1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic last_ff, last_in;
   logic done_k, done_j, done_i;

   assign done_k = (k_ff == 2'd2);
   assign done_j = (j_ff == 2'd2);
   assign done_i = (i_ff == 2'd2);

   // next state
   always_comb begin
      state_in = state_ff;
      i_in = i_ff; j_in = j_ff; k_in = k_ff;
      last_in = last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               state_in = ST_ROT; last_in = in_last;
               i_in = '0; j_in = '0; k_in = '0;
            end
         end
         ST_ROT: begin
            // i = entry row, j = col, k = term (two terms)
            if (k_ff == 2'd1) begin
               k_in = '0;
               if (done_j) begin
                  j_in = '0;
                  if (done_i) begin i_in = '0; state_in = ST_TRANS; end
                  else i_in = i_ff + 2'd1;
               end else j_in = j_ff + 2'd1;
            end else k_in = k_ff + 2'd1;
         end
         ST_TRANS: begin
            if (done_k) begin
               k_in = '0;
               if (done_i) begin i_in = '0; state_in = ST_LIN; end
               else i_in = i_ff + 2'd1;
            end else k_in = k_ff + 2'd1;
         end
         ST_LIN, ST_SCALE: begin
            if (done_k || state_ff == ST_SCALE) begin
               k_in = '0;
               if (done_j) begin
                  j_in = '0;
                  if (done_i) begin
                     i_in = '0;
                     if (state_ff == ST_LIN) state_in = ST_SCALE;
                     else state_in = last_ff ? ST_OUT : ST_IDLE;
                  end else i_in = i_ff + 2'd1;
               end else j_in = j_ff + 2'd1;
            end else k_in = k_ff + 2'd1;
         end
         ST_OUT: if (out_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      cmd.i = i_ff; cmd.j = j_ff; cmd.k = k_ff;
      in_ready = 1'b0;
      out_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            cmd.load = in_valid;
         end
         ST_ROT: begin
            cmd.op = OP_ROT; cmd.acc_en = 1'b1; cmd.acc_clr = (k_ff == 2'd0);
            cmd.store = (k_ff == 2'd1);
         end
         ST_TRANS: begin
            cmd.op = OP_TRANS; cmd.acc_en = 1'b1; cmd.acc_clr = (k_ff == 2'd0);
            cmd.store = done_k;
         end
         ST_LIN: begin
            cmd.op = OP_LIN; cmd.acc_en = 1'b1; cmd.acc_clr = (k_ff == 2'd0);
            cmd.store = done_k;
         end
         ST_SCALE: begin
            cmd.op = OP_SCALE; cmd.acc_en = 1'b1; cmd.acc_clr = 1'b1;
            cmd.store = 1'b1;
            cmd.commit = done_i && done_j;
         end
         ST_OUT: out_valid = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff <= '0; j_ff <= '0; k_ff <= '0; last_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         i_ff <= i_in; j_ff <= j_in; k_ff <= k_in; last_ff <= last_in;
      end
   end

   `TRS_ASSERT_NOW(a_ready_idle, clock, reset, in_ready, state_ff == ST_IDLE)
   `TRS_ASSERT_NOW(a_excl, clock, reset, out_valid, !in_ready)
   `TRS_ASSERT_NEXT(a_out_hold, clock, reset, out_valid && !out_ready, out_valid)
endmodule

### src/trs_dp.sv
// Datapath: operand registers, shared multiplier, accumulator and matrix state
module trs_dp #(
   parameter int COORD_WIDTH = trs_pkg::COORD_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  trs_pkg::trs_cmd_type cmd,
   input  logic [257:0]         in_data,
   output logic [383:0]         out_data
);
   import trs_pkg::*;

   localparam int SAT_BITS = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
   localparam logic signed [ACC_W-1:0] SAT_HI = (ACC_W'(1) <<< (SAT_BITS - 1)) - 1;
   localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - 1;
   localparam logic signed [31:0] ONE = 32'sd65536;

   logic signed [31:0] pos_ff [3];
   logic signed [31:0] scl_ff [3];
   logic signed [15:0] q_ff [4];   // w x y z
   logic signed [31:0] rot_ff [9];
   logic signed [31:0] lin_ff [9];
   logic signed [31:0] m_ff [9];
   logic signed [31:0] tr_ff [3];
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [MUL_W-1:0] opa, opb;
   logic signed [2*MUL_W-1:0] prod;
   logic signed [ACC_W-1:0] rnd, sat_v;
   logic sign_neg;
   logic [3:0] e;
   logic restart_ff;

   assign e = 4'(cmd.i) * 4'd3 + 4'(cmd.j);

   // rotation term selection: (a*b) sign per entry
   function automatic logic [4:0] rot_term(input logic [3:0] idx, input logic t);
      // returns {neg, ia[1:0], ib[1:0]} indices into q: 0=w 1=x 2=y 3=z
      logic [4:0] r;
      begin
         case ({idx, t})
            {4'd0,1'b0}: r = {1'b0,2'd2,2'd2}; {4'd0,1'b1}: r = {1'b0,2'd3,2'd3};
            {4'd1,1'b0}: r = {1'b0,2'd1,2'd2}; {4'd1,1'b1}: r = {1'b1,2'd0,2'd3};
            {4'd2,1'b0}: r = {1'b0,2'd1,2'd3}; {4'd2,1'b1}: r = {1'b0,2'd0,2'd2};
            {4'd3,1'b0}: r = {1'b0,2'd1,2'd2}; {4'd3,1'b1}: r = {1'b0,2'd0,2'd3};
            {4'd4,1'b0}: r = {1'b0,2'd1,2'd1}; {4'd4,1'b1}: r = {1'b0,2'd3,2'd3};
            {4'd5,1'b0}: r = {1'b0,2'd2,2'd3}; {4'd5,1'b1}: r = {1'b1,2'd0,2'd1};
            {4'd6,1'b0}: r = {1'b0,2'd1,2'd3}; {4'd6,1'b1}: r = {1'b1,2'd0,2'd2};
            {4'd7,1'b0}: r = {1'b0,2'd2,2'd3}; {4'd7,1'b1}: r = {1'b0,2'd0,2'd1};
            {4'd8,1'b0}: r = {1'b0,2'd1,2'd1}; {4'd8,1'b1}: r = {1'b0,2'd2,2'd2};
            default: r = '0;
         endcase
         return r;
      end
   endfunction

   logic [4:0] rt;
   logic diag;
   assign rt = rot_term(e, cmd.k[0]);
   assign diag = (e == 4'd0) || (e == 4'd4) || (e == 4'd8);

   // lin source honors a pending identity restart
   function automatic logic signed [31:0] lsel(input logic signed [31:0] v,
                                               input logic rs, input logic [3:0] ix);
      begin
         if (!rs) return v;
         return ((ix == 4'd0) || (ix == 4'd4) || (ix == 4'd8)) ? ONE : 32'sd0;
      end
   endfunction

   // multiplier operand selection
   always_comb begin
      opa = '0; opb = '0; sign_neg = 1'b0;
      case (cmd.op)
         OP_ROT: begin
            opa = MUL_W'(q_ff[rt[3:2]]);
            opb = MUL_W'(q_ff[rt[1:0]]);
            sign_neg = rt[4];
         end
         OP_TRANS: begin
            opa = MUL_W'(lsel(lin_ff[4'(cmd.i)*4'd3 + 4'(cmd.k)], restart_ff,
                              4'(cmd.i)*4'd3 + 4'(cmd.k)));
            opb = MUL_W'(pos_ff[cmd.k]);
         end
         OP_LIN: begin
            opa = MUL_W'(lsel(lin_ff[4'(cmd.i)*4'd3 + 4'(cmd.k)], restart_ff,
                              4'(cmd.i)*4'd3 + 4'(cmd.k)));
            opb = MUL_W'(rot_ff[4'(cmd.k)*4'd3 + 4'(cmd.j)]);
         end
         OP_SCALE: begin
            opa = MUL_W'(m_ff[e]);
            opb = MUL_W'(scl_ff[cmd.j]);
         end
         default: ;
      endcase
   end

   assign prod = opa * opb;

   always_comb begin
      logic signed [ACC_W-1:0] base;
      base = cmd.acc_clr ? '0 : acc_ff;
      acc_in = sign_neg ? base - ACC_W'(prod) : base + ACC_W'(prod);
   end

   // rounding and saturation of the finished sum
   always_comb begin
      if (cmd.op == OP_ROT) begin
         rnd = (acc_in + ACC_W'(1024)) >>> 11;
         if (diag) rnd = ACC_W'(ONE) - rnd;
      end else begin
         rnd = (acc_in + ACC_W'(32768)) >>> 16;
         if (cmd.op == OP_TRANS)
            rnd = rnd + (restart_ff ? '0 : ACC_W'(tr_ff[cmd.i]));
      end
      sat_v = (rnd > SAT_HI) ? SAT_HI : ((rnd < SAT_LO) ? SAT_LO : rnd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         restart_ff <= 1'b0;
         for (int n = 0; n < 9; n++)
            lin_ff[n] <= ((n % 4) == 0) ? ONE : 32'sd0;
         for (int n = 0; n < 3; n++) tr_ff[n] <= '0;
      end else begin
         if (cmd.load) begin
            restart_ff <= in_data[256];
            for (int n = 0; n < 3; n++) begin
               pos_ff[n] <= in_data[32*n +: 32];
               scl_ff[n] <= in_data[160 + 32*n +: 32];
            end
            for (int n = 0; n < 4; n++) q_ff[n] <= in_data[96 + 16*n +: 16];
         end
         if (cmd.acc_en) acc_ff <= acc_in;
         if (cmd.store) begin
            case (cmd.op)
               // rotation entries stay within 22 bits signed and are kept unclamped
               OP_ROT: rot_ff[e] <= rnd[31:0];
               OP_TRANS: tr_ff[cmd.i] <= sat_v[31:0];
               OP_LIN: m_ff[e] <= sat_v[31:0];
               OP_SCALE: lin_ff[e] <= sat_v[31:0];
               default: ;
            endcase
         end
         if (cmd.commit) restart_ff <= 1'b0;
      end
   end

   always_comb begin
      for (int n = 0; n < 9; n++) out_data[32*n +: 32] = lin_ff[n];
      for (int n = 0; n < 3; n++) out_data[288 + 32*n +: 32] = tr_ff[n];
   end
endmodule

### src/trs_hierarchy_compose.sv
// Top level: transform hierarchy composer
// Each level runs rotation, translation, product and scale steps in that order.
// A matrix is emitted only after a level marked last; new levels are taken only when idle.
// A result waits in the output state until taken; the next level is then accepted.
// Synchronous reset sets the running matrix to identity and translation to zero.
module trs_hierarchy_compose #(
   parameter int COORD_WIDTH = trs_pkg::COORD_WIDTH_DEF
) (
   input logic clock,
   input logic reset,
   trs_if.sink   req,
   trs_if.source rsp
);
   import trs_pkg::*;

   trs_cmd_type cmd;
   logic [383:0] dout;

   trs_ctrl u_ctrl (
      .clock, .reset,
      .in_valid(req.valid), .in_last(req.data[257]), .in_ready(req.ready),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .cmd
   );

   trs_dp #(.COORD_WIDTH(COORD_WIDTH)) u_dp (
      .clock, .reset, .cmd, .in_data(req.data[257:0]), .out_data(dout)
   );

   assign rsp.data = dout;
endmodule
